[rtl/core/ftnd_pkg.sv]
// Shared types, constants and codes of the number density unit.
package ftnd_pkg;

  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DIV_X_W     = 96;
  localparam int unsigned DIV_D_W     = 64;
  localparam int unsigned QUO_W       = 48;

  localparam logic [31:0] NEUTRON_Q31  = 32'd2166091413;
  localparam logic [31:0] AVOGADRO_Q32 = 32'd2586489762;
  localparam logic [47:0] MAX48        = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q30      = 64'h0000_0000_4000_0000;
  localparam logic [63:0] ONE_Q40      = 64'h0000_0100_0000_0000;

  typedef enum logic [1:0] {
    REG_DENSITY_VALUE      = 2'd0,
    REG_FRACTION_IS_WEIGHT = 2'd1,
    REG_DENSITY_IS_MASS    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] fraction;
    logic [39:0] molar_mass;
    logic        last;
    logic        store;
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SUM_MUL0,
    ST_SUM_MUL1,
    ST_SUM_ADD,
    ST_SUM_DIV_GO,
    ST_SUM_DIV_WAIT,
    ST_K_MUL,
    ST_K_ROUND,
    ST_READ,
    ST_FETCH,
    ST_N_MUL,
    ST_N_PROD,
    ST_T_DIV_GO,
    ST_T_DIV_WAIT,
    ST_T_MUL0,
    ST_T_MUL1,
    ST_T_PROD,
    ST_N_DIV_WAIT,
    ST_OUT,
    ST_CLEAR
  } back_state_e;

endpackage

[rtl/core/fractions_to_number_densities_unit.sv]
// Top level of the fractions to number densities unit.
//
// Usage: load a material one nuclide per request on the input channel
// (fraction Q8.24, weight ratio Q9.23, last_item on the final nuclide).
// On the last request the unit emits one Q8.40 number density per stored
// nuclide on the output channel, in load order, last_result on the final one.
// Configure density, fraction kind and density kind over APB while idle.
//
// Load requests in weight fraction mode wait on the 48-step quotient loop
// of the shared divider. Emission uses no division for atom density with
// atom fractions, one division with mass density and two divisions for atom
// density with weight fractions; each run adds the Avogadro product and the final clear.
// The front end and a two-entry queue take further requests while the back
// end works, so the input stalls only when the queue is full.
//
// Reset clears control state, the normalizing sum and the counts; the
// nuclide stores are not cleared, only entries written in a run are read.
// A stalled receiver holds the output register; the back end then waits.
module fractions_to_number_densities_unit #(
  parameter int unsigned MAX_NUCLIDES = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [31:0]                     fraction_i,
  input  logic [31:0]                     weight_ratio_i,
  input  logic                            last_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [4:0]                      nuclide_index_o,
  output logic [47:0]                     number_density_o,
  output logic                            last_result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ftnd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [31:0]     density_q;
  logic            frac_weight_q;
  logic            dens_mass_q;
  logic            cfg_wr;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  ftnd_pkg::item_t push_data, pop_data;

  // Configuration registers: write on the access phase of an APB write.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      density_q     <= '0;
      frac_weight_q <= 1'b0;
      dens_mass_q   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (ftnd_pkg::reg_idx_e'(paddr[3:2]))
        ftnd_pkg::REG_DENSITY_VALUE:      density_q     <= pwdata;
        ftnd_pkg::REG_FRACTION_IS_WEIGHT: frac_weight_q <= pwdata[0];
        ftnd_pkg::REG_DENSITY_IS_MASS:    dens_mass_q   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (ftnd_pkg::reg_idx_e'(paddr[3:2]))
      ftnd_pkg::REG_DENSITY_VALUE:      prdata = density_q;
      ftnd_pkg::REG_FRACTION_IS_WEIGHT: prdata = {31'b0, frac_weight_q};
      ftnd_pkg::REG_DENSITY_IS_MASS:    prdata = {31'b0, dens_mass_q};
      default:                          prdata = '0;
    endcase
  end

  // Front end: accept the request and form the molar mass.
  ftnd_front #(.MAX_NUCLIDES(MAX_NUCLIDES)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .fraction_i     (fraction_i),
    .weight_ratio_i (weight_ratio_i),
    .last_item_i    (last_item_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  // Decouple the two halves.
  ftnd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back end: accumulate, then emit densities through the output register.
  ftnd_back #(.MAX_NUCLIDES(MAX_NUCLIDES)) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .pop_valid_i          (pop_valid),
    .pop_ready_o          (pop_ready),
    .pop_data_i           (pop_data),
    .density_value_i      (density_q),
    .fraction_is_weight_i (frac_weight_q),
    .density_is_mass_i    (dens_mass_q),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .nuclide_index_o      (nuclide_index_o),
    .number_density_o     (number_density_o),
    .last_result_o        (last_result_o)
  );

endmodule

[rtl/core/ftnd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ftnd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ftnd_front.sv]
// Front end: accept nuclides, form the molar mass and classify store or drop.
module ftnd_front #(
  parameter int unsigned MAX_NUCLIDES = 32,
  localparam int unsigned CW = $clog2(MAX_NUCLIDES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         fraction_i,
  input  logic [31:0]         weight_ratio_i,
  input  logic                last_item_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output ftnd_pkg::item_t     push_data_o
);

  logic           stage_valid_q, stage_valid_d;
  logic [31:0]    frac_q;
  logic [63:0]    prod_q;
  logic           last_q, store_q;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           accept;
  logic           store_now;
  logic [63:0]    rounded;

  assign in_ready_o = !stage_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign store_now  = (cnt_q < CW'(MAX_NUCLIDES));

  always_comb begin
    stage_valid_d = stage_valid_q;
    cnt_d         = cnt_q;
    if (stage_valid_q && push_ready_i) begin
      stage_valid_d = 1'b0;
    end
    if (accept) begin
      stage_valid_d = 1'b1;
      if (last_item_i) begin
        cnt_d = '0;
      end else if (store_now) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      cnt_q         <= '0;
    end else begin
      stage_valid_q <= stage_valid_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frac_q  <= fraction_i;
      prod_q  <= 64'(weight_ratio_i) * 64'(ftnd_pkg::NEUTRON_Q31);
      last_q  <= last_item_i;
      store_q <= store_now;
    end
  end

  // Round the Q10.54 product to Q10.30.
  assign rounded = prod_q + 64'h0000_0000_0080_0000;

  assign push_valid_o           = stage_valid_q;
  assign push_data_o.fraction   = frac_q;
  assign push_data_o.molar_mass = rounded[63:24];
  assign push_data_o.last       = last_q;
  assign push_data_o.store      = store_q;

endmodule

[rtl/core/ftnd_queue.sv]
// Short queue between the front and back ends.
module ftnd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ftnd_pkg::item_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ftnd_pkg::item_t pop_data_o
);

  localparam int unsigned PW = $clog2(ftnd_pkg::QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(ftnd_pkg::QUEUE_DEPTH + 1);

  ftnd_pkg::item_t entry_q [ftnd_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [NW-1:0]   num_q;
  logic            push, pop;

  assign push_ready_o = (num_q != NW'(ftnd_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (num_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(ftnd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(ftnd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        num_q <= num_q + 1'b1;
      end else if (pop && !push) begin
        num_q <= num_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/ftnd_divider.sv]
// Restoring divider, one quotient bit a cycle, 48-bit saturating quotient.
module ftnd_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ftnd_pkg::DIV_X_W-1:0]  x_i,
  input  logic [ftnd_pkg::DIV_D_W-1:0]  d_i,
  output logic                          done_o,
  output logic [ftnd_pkg::QUO_W-1:0]    quo_o
);

  logic        busy_q, done_q;
  logic [5:0]  step_q;
  logic [63:0] rem_q, d_q;
  logic [47:0] xl_q, quo_q;
  logic [64:0] rem2;
  logic        fits;
  logic [64:0] diff;

  assign rem2 = {rem_q, xl_q[47]};
  assign fits = (rem2 >= {1'b0, d_q});
  assign diff = rem2 - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // Quotient of 2^48 or more, or a zero divisor: saturate at once.
        if ((d_i == '0) || ({16'b0, x_i[95:48]} >= d_i)) begin
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          busy_q <= 1'b1;
          step_q <= 6'd47;
        end
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {16'b0, x_i[95:48]};
      xl_q  <= x_i[47:0];
      d_q   <= d_i;
      quo_q <= ftnd_pkg::MAX48;
    end else if (busy_q) begin
      rem_q <= fits ? diff[63:0] : rem2[63:0];
      xl_q  <= {xl_q[46:0], 1'b0};
      quo_q <= {quo_q[46:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/ftnd_back.sv]
// Back end: stores, normalizing sum and per-nuclide density emission.
module ftnd_back #(
  parameter int unsigned MAX_NUCLIDES = 32,
  localparam int unsigned CW = $clog2(MAX_NUCLIDES + 1),
  localparam int unsigned AW = (MAX_NUCLIDES > 1) ? $clog2(MAX_NUCLIDES) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  ftnd_pkg::item_t pop_data_i,
  input  logic [31:0]     density_value_i,
  input  logic            fraction_is_weight_i,
  input  logic            density_is_mass_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [4:0]      nuclide_index_o,
  output logic [47:0]     number_density_o,
  output logic            last_result_o
);

  ftnd_pkg::back_state_e state_q, state_d;

  ftnd_pkg::item_t ent_q;
  logic [CW-1:0]   cnt_q, idx_q;
  logic [63:0]     norm_q, mul_q, acc_q;
  logic [31:0]     k_q, fi_q;
  logic [39:0]     ai_q;
  logic [47:0]     t_q, n_q;
  logic            out_valid_q;
  logic [4:0]      out_idx_q;
  logic [47:0]     out_n_q;
  logic            out_last_q;

  logic [31:0]     mul_a, mul_b;
  logic            div_start, div_done;
  logic [95:0]     div_x;
  logic [63:0]     div_d;
  logic [47:0]     div_q;
  logic [31:0]     ram_f;
  logic [39:0]     ram_a;
  logic            ram_we, ram_re;
  logic [79:0]     wide;
  logic [63:0]     k_round;
  logic [63:0]     s_fix30, s_fix40;
  logic            out_free, is_last;

  assign wide     = {16'b0, acc_q} + {mul_q[47:0], 32'b0};
  assign k_round  = mul_q + 64'h0000_0000_8000_0000;
  assign s_fix30  = (norm_q == '0) ? ftnd_pkg::ONE_Q30 : norm_q;
  assign s_fix40  = (norm_q == '0) ? ftnd_pkg::ONE_Q40 : norm_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign is_last  = (CW'(idx_q + 1'b1) == cnt_q);

  ftnd_ram #(.WIDTH(32), .DEPTH(MAX_NUCLIDES)) u_frac_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (pop_data_i.fraction),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_f)
  );

  ftnd_ram #(.WIDTH(40), .DEPTH(MAX_NUCLIDES)) u_mass_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (pop_data_i.molar_mass),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_a)
  );

  ftnd_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (div_x),
    .d_i     (div_d),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    mul_a       = density_value_i;
    mul_b       = fi_q;
    div_start   = 1'b0;
    div_x       = {18'b0, fi_q, 46'b0};
    div_d       = {24'b0, ai_q};
    unique case (state_q)
      ftnd_pkg::ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          ram_we = pop_data_i.store;
          if (pop_data_i.store) begin
            state_d = fraction_is_weight_i ? ftnd_pkg::ST_SUM_DIV_GO
                                           : ftnd_pkg::ST_SUM_MUL0;
          end else if (pop_data_i.last) begin
            state_d = ftnd_pkg::ST_K_MUL;
          end
        end
      end
      ftnd_pkg::ST_SUM_MUL0: begin
        mul_a   = ent_q.fraction;
        mul_b   = ent_q.molar_mass[31:0];
        state_d = ftnd_pkg::ST_SUM_MUL1;
      end
      ftnd_pkg::ST_SUM_MUL1: begin
        mul_a   = ent_q.fraction;
        mul_b   = {24'b0, ent_q.molar_mass[39:32]};
        state_d = ftnd_pkg::ST_SUM_ADD;
      end
      ftnd_pkg::ST_SUM_ADD: begin
        state_d = ent_q.last ? ftnd_pkg::ST_K_MUL : ftnd_pkg::ST_IDLE;
      end
      ftnd_pkg::ST_SUM_DIV_GO: begin
        div_start = 1'b1;
        div_x     = {18'b0, ent_q.fraction, 46'b0};
        div_d     = {24'b0, ent_q.molar_mass};
        state_d   = ftnd_pkg::ST_SUM_DIV_WAIT;
      end
      ftnd_pkg::ST_SUM_DIV_WAIT: begin
        if (div_done) begin
          state_d = ent_q.last ? ftnd_pkg::ST_K_MUL : ftnd_pkg::ST_IDLE;
        end
      end
      ftnd_pkg::ST_K_MUL: begin
        mul_b   = ftnd_pkg::AVOGADRO_Q32;
        state_d = ftnd_pkg::ST_K_ROUND;
      end
      ftnd_pkg::ST_K_ROUND: begin
        state_d = (cnt_q == '0) ? ftnd_pkg::ST_CLEAR : ftnd_pkg::ST_READ;
      end
      ftnd_pkg::ST_READ: begin
        ram_re  = 1'b1;
        state_d = ftnd_pkg::ST_FETCH;
      end
      ftnd_pkg::ST_FETCH: begin
        state_d = (!density_is_mass_i && fraction_is_weight_i) ? ftnd_pkg::ST_T_DIV_GO
                                                               : ftnd_pkg::ST_N_MUL;
      end
      ftnd_pkg::ST_N_MUL: begin
        mul_a   = density_is_mass_i ? k_q : density_value_i;
        state_d = ftnd_pkg::ST_N_PROD;
      end
      ftnd_pkg::ST_N_PROD: begin
        if (density_is_mass_i) begin
          div_start = 1'b1;
          div_x     = {10'b0, mul_q, 22'b0};
          div_d     = fraction_is_weight_i ? {24'b0, ai_q} : s_fix30;
          state_d   = ftnd_pkg::ST_N_DIV_WAIT;
        end else begin
          state_d = ftnd_pkg::ST_OUT;
        end
      end
      ftnd_pkg::ST_T_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ftnd_pkg::ST_T_DIV_WAIT;
      end
      ftnd_pkg::ST_T_DIV_WAIT: begin
        if (div_done) begin
          state_d = ftnd_pkg::ST_T_MUL0;
        end
      end
      ftnd_pkg::ST_T_MUL0: begin
        mul_b   = t_q[31:0];
        state_d = ftnd_pkg::ST_T_MUL1;
      end
      ftnd_pkg::ST_T_MUL1: begin
        mul_b   = {16'b0, t_q[47:32]};
        state_d = ftnd_pkg::ST_T_PROD;
      end
      ftnd_pkg::ST_T_PROD: begin
        div_start = 1'b1;
        div_x     = {wide, 16'b0};
        div_d     = s_fix40;
        state_d   = ftnd_pkg::ST_N_DIV_WAIT;
      end
      ftnd_pkg::ST_N_DIV_WAIT: begin
        if (div_done) begin
          state_d = ftnd_pkg::ST_OUT;
        end
      end
      ftnd_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = is_last ? ftnd_pkg::ST_CLEAR : ftnd_pkg::ST_READ;
        end
      end
      ftnd_pkg::ST_CLEAR: begin
        state_d = ftnd_pkg::ST_IDLE;
      end
      default: begin
        state_d = ftnd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ftnd_pkg::ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      norm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ftnd_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ftnd_pkg::ST_IDLE: begin
          if (ram_we) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ftnd_pkg::ST_SUM_ADD: begin
          norm_q <= norm_q + {16'b0, wide[71:24]};
        end
        ftnd_pkg::ST_SUM_DIV_WAIT: begin
          if (div_done) begin
            norm_q <= norm_q + {16'b0, div_q};
          end
        end
        ftnd_pkg::ST_K_ROUND: begin
          idx_q <= '0;
        end
        ftnd_pkg::ST_OUT: begin
          if (out_free) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ftnd_pkg::ST_CLEAR: begin
          norm_q <= '0;
          cnt_q  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= 64'(mul_a) * 64'(mul_b);
    if (state_q == ftnd_pkg::ST_IDLE && pop_valid_i) begin
      ent_q <= pop_data_i;
    end
    if (state_q == ftnd_pkg::ST_SUM_MUL1 || state_q == ftnd_pkg::ST_T_MUL1) begin
      acc_q <= mul_q;
    end
    if (state_q == ftnd_pkg::ST_K_ROUND) begin
      k_q <= k_round[63:32];
    end
    if (state_q == ftnd_pkg::ST_FETCH) begin
      fi_q <= ram_f;
      ai_q <= ram_a;
    end
    if (state_q == ftnd_pkg::ST_T_DIV_WAIT && div_done) begin
      t_q <= div_q;
    end
    if (state_q == ftnd_pkg::ST_N_PROD) begin
      // Atom density with atom fractions: rho * f in Q8.40, saturated.
      n_q <= (mul_q[63:56] != '0) ? ftnd_pkg::MAX48 : mul_q[55:8];
    end
    if (state_q == ftnd_pkg::ST_N_DIV_WAIT && div_done) begin
      n_q <= div_q;
    end
    if (state_q == ftnd_pkg::ST_OUT && out_free) begin
      out_idx_q  <= 5'(idx_q);
      out_n_q    <= n_q;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign nuclide_index_o  = out_idx_q;
  assign number_density_o = out_n_q;
  assign last_result_o    = out_last_q;

endmodule

[rtl/core/ftnd_checker.sv]
// Port-level checker for the number density unit, bound to the top level.
module ftnd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [4:0]                      nuclide_index_o,
  input logic                            last_result_o,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [ftnd_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [31:0]                     pwdata,
  input logic [31:0]                     prdata,
  input logic                            pready
);

  logic [4:0] exp_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_idx_q <= last_result_o ? '0 : exp_idx_q + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  a_index_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nuclide_index_o == exp_idx_q)
    else $error("densities out of load order");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite &&
     paddr[3:2] == ftnd_pkg::REG_DENSITY_VALUE)
    ##1 (psel && !pwrite && paddr[3:2] == ftnd_pkg::REG_DENSITY_VALUE)
    |-> prdata == $past(pwdata))
    else $error("density register readback mismatch");

endmodule

bind fractions_to_number_densities_unit ftnd_checker u_ftnd_checker (.*);

[sim/testbench.sv]
// Self-checking testbench of the fractions to number densities unit.
module testbench;

  localparam int unsigned NUC_MAX = 32;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 150;

  typedef struct packed {
    logic [4:0]  index;
    logic [47:0] density;
    logic        last;
  } density_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] fraction_i;
  logic [31:0] weight_ratio_i;
  logic        last_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  nuclide_index_o;
  logic [47:0] number_density_o;
  logic        last_result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ftnd_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fractions_to_number_densities_unit #(.MAX_NUCLIDES(NUC_MAX)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .fraction_i, .weight_ratio_i,
    .last_item_i, .out_valid_o, .out_ready_i, .nuclide_index_o,
    .number_density_o, .last_result_o, .psel, .penable, .pwrite, .paddr,
    .pwdata, .prdata, .pready
  );

  // Mirror of the configuration registers and of the material being loaded
  logic [31:0] rho_cfg;
  logic        weight_cfg;
  logic        mass_cfg;
  logic [31:0] frac_mem [NUC_MAX];
  logic [39:0] mass_mem [NUC_MAX];
  logic [63:0] norm_acc;
  int unsigned nuc_count;

  density_res_t density_expect_q[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned requests_sent;
  int unsigned cycles;
  bit          send_steady;
  bit          recv_steady;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Saturating quotient, Q8.40 result; a zero divisor saturates
  function automatic logic [47:0] sat_quotient(logic [127:0] num, logic [63:0] den);
    logic [127:0] q;
    if (den == 64'd0) return ftnd_pkg::MAX48;
    q = num / {64'd0, den};
    return (q > {80'd0, ftnd_pkg::MAX48}) ? ftnd_pkg::MAX48 : q[47:0];
  endfunction

  function automatic logic [47:0] weight_term(logic [31:0] f, logic [39:0] a);
    return sat_quotient({96'd0, f} << 46, {24'd0, a});
  endfunction

  // Fold one accepted nuclide into the mirror; on the last one queue densities
  task automatic predict_nuclide(logic [31:0] f, logic [31:0] awr, logic last);
    logic [63:0]  prod;
    logic [39:0]  a;
    logic [71:0]  fa;
    logic [31:0]  kval;
    logic [63:0]  den;
    logic [127:0] wide;
    logic [47:0]  n;
    density_res_t r;
    if (nuc_count < NUC_MAX) begin
      prod = {32'd0, awr} * {32'd0, ftnd_pkg::NEUTRON_Q31};
      prod = prod + 64'd8388608;
      a = prod[63:24];
      frac_mem[nuc_count] = f;
      mass_mem[nuc_count] = a;
      nuc_count++;
      if (weight_cfg) begin
        norm_acc += {16'd0, weight_term(f, a)};
      end else begin
        fa = {40'd0, f} * {32'd0, a};
        norm_acc += {16'd0, fa[71:24]};
      end
    end
    if (last) begin
      prod = {32'd0, rho_cfg} * {32'd0, ftnd_pkg::AVOGADRO_Q32};
      prod = (prod + 64'h8000_0000) >> 32;
      kval = prod[31:0];
      for (int i = 0; i < nuc_count; i++) begin
        if (mass_cfg) begin
          den = weight_cfg ? {24'd0, mass_mem[i]}
                           : ((norm_acc == 0) ? ftnd_pkg::ONE_Q30 : norm_acc);
          wide = ({96'd0, kval} * {96'd0, frac_mem[i]}) << 22;
          n = sat_quotient(wide, den);
        end else if (!weight_cfg) begin
          prod = ({32'd0, rho_cfg} * {32'd0, frac_mem[i]}) >> 8;
          n = (prod > {16'd0, ftnd_pkg::MAX48}) ? ftnd_pkg::MAX48 : prod[47:0];
        end else begin
          wide = ({96'd0, rho_cfg} * {80'd0, weight_term(frac_mem[i], mass_mem[i])}) << 16;
          n = sat_quotient(wide, (norm_acc == 0) ? ftnd_pkg::ONE_Q40 : norm_acc);
        end
        r.index = i[4:0];
        r.density = n;
        r.last = (i + 1 == nuc_count);
        density_expect_q.push_back(r);
      end
      norm_acc = '0;
      nuc_count = 0;
    end
  endtask

  // Send one nuclide request; entered and left at a falling edge
  task automatic send_nuclide(logic [31:0] f, logic [31:0] awr, logic last);
    if (!send_steady && $urandom_range(99) < 9) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    fraction_i = f;
    weight_ratio_i = awr;
    last_item_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_nuclide(f, awr, last);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Hold off until every density has come, then let the back end settle
  task automatic drain();
    in_valid_i = 1'b0;
    while (density_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(ftnd_pkg::reg_idx_e idx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ftnd_pkg::CFG_ADDR_W'(idx) << 2;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      ftnd_pkg::REG_DENSITY_VALUE:      rho_cfg = value;
      ftnd_pkg::REG_FRACTION_IS_WEIGHT: weight_cfg = value[0];
      default:                          mass_cfg = value[0];
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_mode(logic [31:0] rho, logic w, logic m);
    cfg_write(ftnd_pkg::REG_DENSITY_VALUE, rho);
    cfg_write(ftnd_pkg::REG_FRACTION_IS_WEIGHT, {31'd0, w});
    cfg_write(ftnd_pkg::REG_DENSITY_IS_MASS, {31'd0, m});
  endtask

  // Random fraction or weight ratio: full range, small, or extreme
  function automatic logic [31:0] pick_field();
    case ($urandom_range(7))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'd0;
      2, 3:    return $urandom_range(32'h0200_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_material(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_nuclide(pick_field(), pick_field(), i + 1 == len);
  endtask

  // Hydrogen and oxygen like nuclides in every mode
  task automatic test_modes();
    for (int mode = 0; mode < 4; mode++) begin
      set_mode(32'h0100_0000, mode[1], mode[0]);
      send_nuclide(32'h00AA_AAAB, 32'h007F_FFFF, 1'b0);
      send_nuclide(32'h0055_5555, 32'h07EF_8000, 1'b1);
      drain();
    end
  endtask

  // Field extremes, zero molar mass and a single nuclide material
  task automatic test_extremes();
    set_mode(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_nuclide(32'hFFFF_FFFF, 32'd0, 1'b0);
    send_nuclide(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_nuclide(32'd0, 32'hFFFF_FFFF, 1'b1);
    drain();
    set_mode(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_nuclide(32'hFFFF_FFFF, 32'd0, 1'b1);
    drain();
    set_mode(32'd0, 1'b1, 1'b0);
    send_nuclide(32'd0, 32'd0, 1'b1);
    drain();
    // zero normalizing sum is replaced by one
    set_mode(32'h0100_0000, 1'b0, 1'b1);
    send_nuclide(32'h0100_0000, 32'd0, 1'b1);
    drain();
  endtask

  // Overfill the store: extra nuclides drop out but last still triggers
  task automatic test_store_full();
    set_mode(32'h0080_0000, 1'b0, 1'b0);
    send_steady = 1'b1;
    recv_steady = 1'b1;
    send_material(NUC_MAX + 3);
    send_steady = 1'b0;
    drain();
    recv_steady = 1'b0;
  endtask

  // Change the fraction kind between nuclides of one material
  task automatic test_mode_switch();
    set_mode(32'h0200_0000, 1'b0, 1'b1);
    send_nuclide(32'h0080_0000, 32'h0100_0000, 1'b0);
    drain();
    cfg_write(ftnd_pkg::REG_FRACTION_IS_WEIGHT, 32'd1);
    send_nuclide(32'h0080_0000, 32'h0800_0000, 1'b1);
    drain();
  endtask

  task automatic test_random();
    int unsigned target;
    target = requests_sent + 110;
    while (requests_sent < target) begin
      set_mode($urandom_range(3) == 0 ? ($urandom_range(1) ? 32'hFFFF_FFFF : 32'd0) : $urandom,
               1'($urandom_range(1)), 1'($urandom_range(1)));
      // mostly short materials, now and then a long one that may fill the store
      send_material($urandom_range(9) == 0 ? $urandom_range(28, NUC_MAX + 2)
                                           : $urandom_range(1, 6));
      if ($urandom_range(1)) send_material($urandom_range(1, 4));
      drain();
    end
  endtask

  // Receiver: stall at random, with a steady stretch in the middle
  always @(negedge clk_i) begin
    out_ready_i <= recv_steady || ($urandom_range(99) >= 9);
  end

  // Compare every accepted density with the oldest expectation
  always @(posedge clk_i) begin
    density_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (density_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected density: index %0d value %h last %b",
                   nuclide_index_o, number_density_o, last_result_o);
      end else begin
        exp_r = density_expect_q.pop_front();
        if (exp_r.index != nuclide_index_o || exp_r.density != number_density_o ||
            exp_r.last != last_result_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("density mismatch: expected %0d/%h/%b got %0d/%h/%b",
                     exp_r.index, exp_r.density, exp_r.last,
                     nuclide_index_o, number_density_o, last_result_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    in_valid_i = 1'b0;
    fraction_i = '0;
    weight_ratio_i = '0;
    last_item_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    rho_cfg = '0;
    weight_cfg = 1'b0;
    mass_cfg = 1'b1;
    norm_acc = '0;
    nuc_count = 0;
    mismatches = 0;
    results_seen = 0;
    requests_sent = 0;
    cycles = 0;
    send_steady = 1'b0;
    recv_steady = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_modes();
    test_extremes();
    test_store_full();
    test_mode_switch();
    test_random();

    drain();
    $display("sent %0d nuclide requests over all four modes, checked %0d densities",
             requests_sent, results_seen);
    $display("covered field extremes, zero molar mass, full store, mode switch");
    if (mismatches == 0 && density_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d densities missing", mismatches, density_expect_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
